// File: rtl/upsc_pkg.sv
// ----------------------------------------------------------------------------
// upsc_pkg
// Shared types and constants for the pixel replication upscaler.
// ----------------------------------------------------------------------------
package upsc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF = 100;

  localparam int SCALE_W      = 7;
  localparam int SRC_WIDTH_W  = 11;
  localparam int SRC_HEIGHT_W = 16;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  // Command carried in s_tuser
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef enum logic [2:0] {
    KIND_PIXEL  = 3'd0,
    KIND_PAD    = 3'd1,
    KIND_WAIT   = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_REJECT = 3'd4
  } beat_kind_t;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Result of one item, minus pixel bytes
  typedef struct packed {
    beat_kind_t kind;
    logic       row_end;
    logic       image_end;
  } beat_meta_t;

endpackage

// File: rtl/upsc_regs.sv
// ----------------------------------------------------------------------------
// upsc_regs
// APB register file; also clamps the registers to their effective values.
// ----------------------------------------------------------------------------
module upsc_regs #(
  parameter int MAX_WIDTH = upsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = upsc_pkg::MAX_SCALE_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [upsc_pkg::APB_AW-1:0]     paddr,
  input  logic [upsc_pkg::APB_DW-1:0]     pwdata,
  output logic [upsc_pkg::APB_DW-1:0]     prdata,
  output logic [SW-1:0]                   eff_scale,
  output logic [WW-1:0]                   eff_width,
  output logic [upsc_pkg::SRC_HEIGHT_W-1:0] eff_height
);

  logic [upsc_pkg::SCALE_W-1:0]      scale;
  logic [upsc_pkg::SRC_WIDTH_W-1:0]  source_width;
  logic [upsc_pkg::SRC_HEIGHT_W-1:0] source_height;
  upsc_pkg::reg_idx_t                idx;
  logic                              wr;

  assign idx = upsc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= upsc_pkg::SCALE_W'(1);
      source_width  <= upsc_pkg::SRC_WIDTH_W'(1);
      source_height <= upsc_pkg::SRC_HEIGHT_W'(1);
    end else if (wr) begin
      unique case (idx)
        upsc_pkg::REG_SCALE:  scale         <= pwdata[upsc_pkg::SCALE_W-1:0];
        upsc_pkg::REG_WIDTH:  source_width  <= pwdata[upsc_pkg::SRC_WIDTH_W-1:0];
        upsc_pkg::REG_HEIGHT: source_height <= pwdata[upsc_pkg::SRC_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      upsc_pkg::REG_SCALE:  prdata = upsc_pkg::APB_DW'(scale);
      upsc_pkg::REG_WIDTH:  prdata = upsc_pkg::APB_DW'(source_width);
      upsc_pkg::REG_HEIGHT: prdata = upsc_pkg::APB_DW'(source_height);
      default:              prdata = '0;
    endcase
  end

  // zero acts as one, too large saturates
  always_comb begin
    if (scale == '0) begin
      eff_scale = SW'(1);
    end else if (32'(scale) > 32'(MAX_SCALE)) begin
      eff_scale = SW'(MAX_SCALE);
    end else begin
      eff_scale = SW'(scale);
    end
    if (source_width == '0) begin
      eff_width = WW'(1);
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(source_width);
    end
    eff_height = (source_height == '0) ? upsc_pkg::SRC_HEIGHT_W'(1) : source_height;
  end

endmodule

// File: rtl/upsc_line_mem.sv
// ----------------------------------------------------------------------------
// upsc_line_mem
// One-row pixel store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module upsc_line_mem #(
  parameter int DEPTH = upsc_pkg::MAX_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [upsc_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [upsc_pkg::PIX_W-1:0] rdata
);

  logic [upsc_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // holds while the output stage is stalled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/upsc_ctrl.sv
// ----------------------------------------------------------------------------
// upsc_ctrl
// Row/column/copy counters; decides each beat and drives the line store.
// ----------------------------------------------------------------------------
module upsc_ctrl #(
  parameter int MAX_WIDTH = upsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = upsc_pkg::MAX_SCALE_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int SW = $clog2(MAX_SCALE + 1),
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int HW = upsc_pkg::SRC_HEIGHT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 command,
  input  logic [SW-1:0]        eff_scale,
  input  logic [WW-1:0]        eff_width,
  input  logic [HW-1:0]        eff_height,
  output upsc_pkg::beat_meta_t meta,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr
);

  logic [WW-1:0] filled_count, filled_count_next;
  logic [AW-1:0] source_column, source_column_next;
  logic [SW-1:0] horizontal_copy, horizontal_copy_next;
  logic [SW-1:0] vertical_copy, vertical_copy_next;
  logic [HW-1:0] source_row, source_row_next;
  logic [1:0]    pad_left, pad_left_next;
  logic          in_padding, in_padding_next;

  logic [WW-1:0] col;
  logic [WW-1:0] col_inc;
  logic [SW:0]   h_inc;
  logic [SW:0]   v_inc;
  logic [HW:0]   row_inc;
  logic [1:0]    pad_dec;
  logic [WW+1:0] w_ext;
  logic [SW+1:0] s_ext;
  logic [3:0]    pad_prod;
  logic          line_done;
  logic          do_we;
  logic          do_re;

  assign w_ext    = (WW+2)'(eff_width);
  assign s_ext    = (SW+2)'(eff_scale);
  // pad bytes = (w*s) mod 4, since 3*w*s == -(w*s) mod 4
  assign pad_prod = w_ext[1:0] * s_ext[1:0];

  // a column beyond a shrunken width reads as the last column
  assign col     = (WW'(source_column) >= eff_width) ? eff_width - WW'(1)
                                                     : WW'(source_column);
  assign col_inc = col + WW'(1);
  assign h_inc   = (SW+1)'(horizontal_copy) + (SW+1)'(1);
  assign v_inc   = (SW+1)'(vertical_copy) + (SW+1)'(1);
  assign row_inc = (HW+1)'(source_row) + (HW+1)'(1);
  assign pad_dec = (pad_left != 2'd0) ? pad_left - 2'd1 : 2'd0;

  always_comb begin
    filled_count_next    = filled_count;
    source_column_next   = source_column;
    horizontal_copy_next = horizontal_copy;
    vertical_copy_next   = vertical_copy;
    source_row_next      = source_row;
    pad_left_next        = pad_left;
    in_padding_next      = in_padding;
    meta.kind            = upsc_pkg::KIND_WAIT;
    meta.row_end         = 1'b0;
    meta.image_end       = 1'b0;
    line_done            = 1'b0;
    do_we                = 1'b0;
    do_re                = 1'b0;

    if (command == upsc_pkg::CMD_PUSH) begin
      if (filled_count >= eff_width) begin
        meta.kind = upsc_pkg::KIND_REJECT;
      end else begin
        meta.kind         = upsc_pkg::KIND_ACCEPT;
        do_we             = 1'b1;
        filled_count_next = filled_count + WW'(1);
      end
    end else if (in_padding) begin
      meta.kind     = upsc_pkg::KIND_PAD;
      pad_left_next = pad_dec;
      if (pad_dec == 2'd0) begin
        line_done = 1'b1;
      end
    end else if (col >= filled_count) begin
      meta.kind = upsc_pkg::KIND_WAIT;
    end else begin
      meta.kind          = upsc_pkg::KIND_PIXEL;
      do_re              = 1'b1;
      source_column_next = col[AW-1:0];
      if (h_inc >= (SW+1)'(eff_scale)) begin
        horizontal_copy_next = '0;
        if (col_inc >= eff_width) begin
          source_column_next = '0;
          if (pad_prod[1:0] != 2'd0) begin
            in_padding_next = 1'b1;
            pad_left_next   = pad_prod[1:0];
          end else begin
            line_done = 1'b1;
          end
        end else begin
          source_column_next = col_inc[AW-1:0];
        end
      end else begin
        horizontal_copy_next = h_inc[SW-1:0];
      end
    end

    // close an output scanline
    if (line_done) begin
      meta.row_end    = 1'b1;
      in_padding_next = 1'b0;
      pad_left_next   = 2'd0;
      if (v_inc >= (SW+1)'(eff_scale)) begin
        vertical_copy_next = '0;
        filled_count_next  = '0;
        if (row_inc >= (HW+1)'(eff_height)) begin
          source_row_next = '0;
          meta.image_end  = 1'b1;
        end else begin
          source_row_next = row_inc[HW-1:0];
        end
      end else begin
        vertical_copy_next = v_inc[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count    <= '0;
      source_column   <= '0;
      horizontal_copy <= '0;
      vertical_copy   <= '0;
      source_row      <= '0;
      pad_left        <= '0;
      in_padding      <= 1'b0;
    end else if (accept) begin
      filled_count    <= filled_count_next;
      source_column   <= source_column_next;
      horizontal_copy <= horizontal_copy_next;
      vertical_copy   <= vertical_copy_next;
      source_row      <= source_row_next;
      pad_left        <= pad_left_next;
      in_padding      <= in_padding_next;
    end
  end

  assign mem_we    = accept & do_we;
  assign mem_waddr = filled_count[AW-1:0];
  assign mem_re    = accept & do_re;
  assign mem_raddr = col[AW-1:0];

endmodule

// File: rtl/pixel_replication_upscaler_core.sv
// ----------------------------------------------------------------------------
// pixel_replication_upscaler_core
// Integer nearest-neighbor upscaler for rows of 24-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries commands: s_tuser = 0 pushes the pixel in s_tdata into
//   the line store, s_tuser = 1 pulls the next output beat. Every accepted
//   transfer yields exactly one transfer on m_*, in order. m_tuser[2:0] tells
//   the beat kind (pixel, pad byte, not ready, push accepted, push rejected),
//   m_tuser[3] flags the last beat of the image, m_tlast the last beat of an
//   output scanline. m_tdata holds pixel bytes only on pixel beats.
//   Registers (scale, source_width, source_height) sit on the APB port at
//   byte addresses 0, 4, 8; change them only while the stream is idle.
// Timing:
//   The result of an accepted transfer is registered and valid in the next
//   cycle. One transfer per cycle while m_tready holds; the line store
//   read port is registered in step with the output register.
//   s_tready = !m_tvalid | m_tready, so a stalled receiver holds the result
//   and back-pressures the input after one item; no result is dropped.
// Reset:
//   rst (synchronous) clears all counters, the output valid and sets the
//   registers to 1. The line store is not cleared; it is never read ahead
//   of being written within the current row. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler_core #(
  parameter int MAX_WIDTH = upsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = upsc_pkg::MAX_SCALE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [upsc_pkg::PIX_W-1:0]  s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  input  logic                        s_tuser,   // [0] command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [upsc_pkg::PIX_W-1:0]  m_tdata,   // [7:0] out_blue, [15:8] out_green,
                                                 // [23:16] out_red
  output logic [3:0]                  m_tuser,   // [2:0] beat_kind, [3] image_end
  output logic                        m_tlast,   // row_end
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [upsc_pkg::APB_AW-1:0] paddr,
  input  logic [upsc_pkg::APB_DW-1:0] pwdata,
  output logic [upsc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [SW-1:0]                     eff_scale;
  logic [WW-1:0]                     eff_width;
  logic [upsc_pkg::SRC_HEIGHT_W-1:0] eff_height;

  logic                       accept;
  upsc_pkg::beat_meta_t       meta;
  upsc_pkg::beat_meta_t       out_meta;   // output register
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [upsc_pkg::PIX_W-1:0] mem_rdata;

  assign pready   = 1'b1;
  // output register frees up when empty or being drained this cycle
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  upsc_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .eff_scale  (eff_scale),
    .eff_width  (eff_width),
    .eff_height (eff_height)
  );

  upsc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (s_tuser),
    .eff_scale  (eff_scale),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .meta       (meta),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  upsc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (s_tdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output stage: beat info registered here, pixel bytes from the store's
  // read register, both loaded on the same accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_meta <= meta;
    end
  end

  assign m_tdata = (out_meta.kind == upsc_pkg::KIND_PIXEL) ? mem_rdata : '0;
  assign m_tuser = {out_meta.image_end, out_meta.kind};
  assign m_tlast = out_meta.row_end;

endmodule

// File: rtl/upsc_checker.sv
// ----------------------------------------------------------------------------
// upsc_checker
// Port-level checks for the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
module upsc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [upsc_pkg::PIX_W-1:0] m_tdata,
  input logic [3:0]                 m_tuser,
  input logic                       m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output changed while stalled");

  // empty output stage always takes a transfer
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output stage");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != upsc_pkg::KIND_PIXEL) |-> m_tdata == '0)
    else $error("nonzero data on non-pixel beat");

  a_img_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tlast)
    else $error("image end without row end");

  a_row_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tuser[2:0] == upsc_pkg::KIND_PIXEL)
                            || (m_tuser[2:0] == upsc_pkg::KIND_PAD))
    else $error("row end on a beat that is not pixel or pad");

endmodule

bind pixel_replication_upscaler_core upsc_checker u_upsc_checker (.*);
